// File: sv/mspid_pkg.sv
// shared types, constants and helper functions for the motor speed/angle pid
`default_nettype none
package mspid_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_A,
        ST_MUL_B,
        ST_MUL_C,
        ST_ACC,
        ST_DIV_INIT,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        MUL_X1,
        MUL_X100,
        MUL_X1000,
        MUL_X10000,
        MUL_X1E6
    } mult_sel_t;

    typedef enum logic [1:0] {
        MODE_VEL  = 2'd0,
        MODE_ANG  = 2'd1,
        MODE_ASYM = 2'd2,
        MODE_OFF  = 2'd3
    } loop_mode_t;

    typedef enum logic [2:0] {
        REG_VEL_KP    = 3'd0,
        REG_VEL_KI    = 3'd1,
        REG_VEL_KD    = 3'd2,
        REG_ANG_KP    = 3'd3,
        REG_ANG_KI    = 3'd4,
        REG_ANG_KD    = 3'd5,
        REG_LOOP_MODE = 3'd6
    } cfg_reg_t;

    localparam int CFG_IDX_W = 3;
    localparam int GAIN_W    = 32;
    localparam int SPEED_W   = 16;
    localparam int DRIVE_W   = 16;
    localparam int ACC_W     = 54;
    localparam int QUO_W     = 15;
    localparam int DIV_Y_W   = 24;

    // reciprocals rounded up; exact floor for any dividend below 2^24
    localparam logic [31:0] RECIP_VA = 32'd17179870;
    localparam logic [31:0] RECIP_AS = 32'd21474837;
    localparam int          RSH_VA   = 34;
    localparam int          RSH_AS   = 31;

    typedef struct packed {
        logic [GAIN_W-1:0] vel_kp;
        logic [GAIN_W-1:0] vel_ki;
        logic [GAIN_W-1:0] vel_kd;
        logic [GAIN_W-1:0] ang_kp;
        logic [GAIN_W-1:0] ang_ki;
        logic [GAIN_W-1:0] ang_kd;
        loop_mode_t        loop_mode;
    } cfg_t;

    typedef struct packed {
        logic       accept;
        logic       mul_a;
        logic       mul_b;
        logic       mul_c;
        logic       acc;
        logic       div_init;
        logic       div_step;
        logic       out_load;
        logic [1:0] term_idx;
    } cmd_t;

    typedef struct packed {
        logic skip;
        logic last_term;
        logic out_busy;
    } status_t;

    localparam logic [63:0] TERM_LIM     = 64'd1 << 50;
    localparam logic [63:0] LIM_X100     = TERM_LIM / 64'd100;
    localparam logic [63:0] LIM_X1000    = TERM_LIM / 64'd1000;
    localparam logic [63:0] LIM_X10000   = TERM_LIM / 64'd10000;
    localparam logic [63:0] LIM_X1E6     = TERM_LIM / 64'd1000000;

    localparam logic [ACC_W-1:0] SCALE_VA  = ACC_W'(65536000);
    localparam logic [ACC_W-1:0] SCALE_AS  = ACC_W'(6553600);
    localparam logic [ACC_W-1:0] ICLAMP    = ACC_W'(5000) * SCALE_VA;
    localparam logic [ACC_W-1:0] OVER_VEL  = ACC_W'(12001) * SCALE_VA;
    localparam logic [ACC_W-1:0] OVER_ANG  = ACC_W'(401) * SCALE_VA;
    localparam logic [ACC_W-1:0] OVER_ASYM = ACC_W'(16385) * SCALE_AS;

    localparam logic [DRIVE_W-1:0] LIM_VEL  = 16'd12000;
    localparam logic [DRIVE_W-1:0] LIM_ANG  = 16'd400;
    localparam logic [DRIVE_W-1:0] LIM_ASYM = 16'd16384;

    function automatic logic [31:0] mult_val(input mult_sel_t s);
        logic [31:0] v;
        case (s)
            MUL_X100:   v = 32'd100;
            MUL_X1000:  v = 32'd1000;
            MUL_X10000: v = 32'd10000;
            MUL_X1E6:   v = 32'd1000000;
            default:    v = 32'd1;
        endcase
        return v;
    endfunction

    // largest first product that still stays under the term limit
    function automatic logic [63:0] mult_lim(input mult_sel_t s);
        logic [63:0] v;
        case (s)
            MUL_X100:   v = LIM_X100;
            MUL_X1000:  v = LIM_X1000;
            MUL_X10000: v = LIM_X10000;
            MUL_X1E6:   v = LIM_X1E6;
            default:    v = TERM_LIM;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
        logic signed [31:0] r;
        if (v > 33'sh0_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -33'sh0_8000_0000) begin
            r = -32'sh8000_0000;
        end else begin
            r = 32'(v);
        end
        return r;
    endfunction

    function automatic logic [31:0] abs33(input logic signed [32:0] v);
        logic signed [32:0] n;
        n = -v;
        return v[32] ? n[31:0] : v[31:0];
    endfunction

endpackage
`default_nettype wire

// File: sv/mspid_ctrl.sv
// sequencer: steps the shared multiplier through the terms, then the divider
`default_nettype none
module mspid_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire mspid_pkg::status_t status,
    output mspid_pkg::cmd_t        cmd
);
    import mspid_pkg::*;

    state_t               state_reg, state_next;
    logic [1:0]           term_reg, term_next;
    logic                 accept;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            term_reg  <= 2'd0;
        end else begin
            state_reg <= state_next;
            term_reg  <= term_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        term_next  = term_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_MUL_A;
                    term_next  = 2'd0;
                end
            end
            ST_MUL_A: begin
                state_next = status.skip ? ST_DONE : ST_MUL_B;
            end
            ST_MUL_B: state_next = ST_MUL_C;
            ST_MUL_C: state_next = ST_ACC;
            ST_ACC: begin
                if (status.last_term) begin
                    state_next = ST_DIV_INIT;
                end else begin
                    state_next = ST_MUL_A;
                    term_next  = term_reg + 2'd1;
                end
            end
            ST_DIV_INIT: state_next = ST_DIV;
            ST_DIV:      state_next = ST_DONE;
            ST_DONE: begin
                if (!status.out_busy) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd          = '0;
        cmd.accept   = accept;
        cmd.term_idx = term_reg;
        case (state_reg)
            ST_MUL_A:    cmd.mul_a    = 1'b1;
            ST_MUL_B:    cmd.mul_b    = 1'b1;
            ST_MUL_C:    cmd.mul_c    = 1'b1;
            ST_ACC:      cmd.acc      = 1'b1;
            ST_DIV_INIT: cmd.div_init = 1'b1;
            ST_DIV:      cmd.div_step = 1'b1;
            ST_DONE:     cmd.out_load = !status.out_busy;
            default:     cmd.accept   = accept;
        endcase
    end

endmodule
`default_nettype wire

// File: sv/mspid_datapath.sv
// per-motor state, error update, shared multiplier, accumulator, divider, output register
`default_nettype none
module mspid_datapath #(
    parameter int  MOTOR_COUNT     = 4,
    parameter int  COUNTS_PER_TURN = 8192,
    localparam int IDX_W           = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1,
    localparam int ENC_W           = $clog2(COUNTS_PER_TURN)
) (
    input  wire logic                                      aclk,
    input  wire logic                                      aresetn,
    input  wire mspid_pkg::cmd_t                           cmd,
    input  wire mspid_pkg::cfg_t                           cfg,
    input  wire logic [IDX_W-1:0]                          s_motor_index,
    input  wire logic [ENC_W-1:0]                          s_encoder,
    input  wire logic signed [mspid_pkg::SPEED_W-1:0]      s_speed,
    input  wire logic signed [mspid_pkg::SPEED_W-1:0]      s_target_speed,
    input  wire logic [ENC_W-1:0]                          s_target_angle,
    input  wire logic                                      m_ready,
    output mspid_pkg::status_t                             status,
    output logic                                           m_valid,
    output logic [IDX_W-1:0]                               m_out_motor,
    output logic signed [mspid_pkg::DRIVE_W-1:0]           m_drive
);
    import mspid_pkg::*;

    localparam int AE_W = ENC_W + 1;
    localparam int AW   = ENC_W + 2;
    localparam logic signed [AW-1:0] CPT_S  = AW'(COUNTS_PER_TURN);
    localparam logic signed [AW-1:0] HALF_S = AW'(COUNTS_PER_TURN / 2);
    localparam logic [IDX_W:0]       MC     = (IDX_W + 1)'(MOTOR_COUNT);

    // per-motor loop state
    logic signed [15:0]     prev_speed_reg [MOTOR_COUNT];
    logic signed [16:0]     vel_err_reg    [MOTOR_COUNT];
    logic signed [31:0]     vel_sum_reg    [MOTOR_COUNT];
    logic signed [AE_W-1:0] ang_err_reg    [MOTOR_COUNT];
    logic signed [31:0]     ang_sum_reg    [MOTOR_COUNT];

    // working copy of the current beat
    logic [IDX_W-1:0]       motor_reg;
    logic signed [16:0]     ve_reg;
    logic signed [17:0]     vd_reg;
    logic signed [31:0]     vsum_reg;
    logic signed [AE_W-1:0] ae_reg;
    logic signed [AE_W:0]   ad_reg;
    logic signed [31:0]     asum_reg;
    logic signed [16:0]     dspd_reg;
    logic                   tsp_le0_reg;
    logic                   skip_reg;

    // term pipeline
    logic [63:0]      p1_reg;
    logic [63:0]      plo_reg;
    logic [63:0]      phi_reg;
    logic             sat_reg;
    logic             neg_reg;
    logic             iclamp_reg;
    logic             difcap_reg;
    mult_sel_t        msel_reg;
    logic [15:0]      difmag_reg;
    logic [ACC_W-1:0] acc_reg;

    // divider
    logic [DIV_Y_W-1:0] y_reg;
    logic [QUO_W-1:0]   q_reg;
    logic               over_reg;
    logic               sign_reg;
    logic [31:0]        recip;
    logic               div_as;

    logic                     m_valid_reg;
    logic [IDX_W-1:0]         m_out_motor_reg;
    logic signed [DRIVE_W-1:0] m_drive_reg;

    // error update at the accepting edge
    logic                   in_range;
    logic signed [16:0]     ve;
    logic signed [17:0]     vd;
    logic signed [31:0]     vsum_n;
    logic signed [AW-1:0]   ae_raw;
    logic signed [AW-1:0]   ae_w;
    logic signed [AE_W-1:0] ae;
    logic signed [AE_W:0]   ad;
    logic signed [31:0]     asum_n;
    logic signed [16:0]     dspd;

    always_comb begin
        in_range = ({1'b0, s_motor_index} < MC);
        ve     = 17'(s_target_speed) - 17'(s_speed);
        vd     = 18'(ve) - 18'(vel_err_reg[s_motor_index]);
        vsum_n = sat32(33'(vel_sum_reg[s_motor_index]) + 33'(ve));
        ae_raw = $signed(AW'(s_target_angle)) - $signed(AW'(s_encoder));
        if (ae_raw > HALF_S) begin
            ae_w = ae_raw - CPT_S;
        end else if (ae_raw < -HALF_S) begin
            ae_w = ae_raw + CPT_S;
        end else begin
            ae_w = ae_raw;
        end
        ae     = AE_W'(ae_w);
        ad     = (AE_W + 1)'(ae) - (AE_W + 1)'(ang_err_reg[s_motor_index]);
        asum_n = sat32(33'(ang_sum_reg[s_motor_index]) + 33'(ae));
        dspd   = 17'(s_speed) - 17'(prev_speed_reg[s_motor_index]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < MOTOR_COUNT; k++) begin
                prev_speed_reg[k] <= '0;
                vel_err_reg[k]    <= '0;
                vel_sum_reg[k]    <= '0;
                ang_err_reg[k]    <= '0;
                ang_sum_reg[k]    <= '0;
            end
        end else if (cmd.accept && in_range) begin
            prev_speed_reg[s_motor_index] <= s_speed;
            vel_err_reg[s_motor_index]    <= ve;
            vel_sum_reg[s_motor_index]    <= vsum_n;
            ang_err_reg[s_motor_index]    <= ae;
            ang_sum_reg[s_motor_index]    <= asum_n;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            motor_reg   <= s_motor_index;
            ve_reg      <= ve;
            vd_reg      <= vd;
            vsum_reg    <= vsum_n;
            ae_reg      <= ae;
            ad_reg      <= ad;
            asum_reg    <= asum_n;
            dspd_reg    <= dspd;
            tsp_le0_reg <= (s_target_speed <= 16'sd0);
            skip_reg    <= !in_range || (cfg.loop_mode == MODE_OFF);
        end
    end

    // operand selection for the current term
    logic                 vd_pos;
    logic [GAIN_W-1:0]    kdd;
    logic [31:0]          op_a;
    logic signed [32:0]   op_x;
    logic                 op_fixed;
    logic                 op_neg;
    logic [31:0]          op_b;
    mult_sel_t            op_msel;
    logic                 op_iclamp;
    logic                 op_difcap;

    always_comb begin
        vd_pos    = (vd_reg > 18'sd0);
        kdd       = vd_pos ? '0 : cfg.vel_kd;
        op_a      = '0;
        op_x      = '0;
        op_fixed  = 1'b0;
        op_msel   = MUL_X1;
        op_iclamp = 1'b0;
        op_difcap = 1'b0;
        case (cfg.loop_mode)
            MODE_VEL: begin
                case (cmd.term_idx)
                    2'd0: begin
                        op_a = cfg.vel_kp; op_x = 33'(ve_reg); op_msel = MUL_X1000;
                    end
                    2'd1: begin
                        op_a = cfg.vel_ki; op_x = 33'(vsum_reg); op_iclamp = 1'b1;
                    end
                    default: begin
                        op_a = cfg.vel_kd; op_x = 33'(vd_reg); op_msel = MUL_X1E6;
                    end
                endcase
            end
            MODE_ANG: begin
                case (cmd.term_idx)
                    2'd0: begin
                        op_a = cfg.ang_kp; op_x = 33'(ae_reg); op_msel = MUL_X1000;
                    end
                    2'd1: begin
                        op_a = cfg.ang_ki; op_x = 33'(asum_reg); op_iclamp = 1'b1;
                    end
                    default: begin
                        op_a = cfg.ang_kd; op_x = 33'(ad_reg); op_msel = MUL_X1E6;
                    end
                endcase
            end
            MODE_ASYM: begin
                case (cmd.term_idx)
                    2'd0: begin
                        op_a = cfg.vel_kp; op_x = 33'(ve_reg); op_msel = MUL_X100;
                    end
                    2'd1: begin
                        op_a = cfg.vel_ki; op_x = 33'(vsum_reg);
                    end
                    2'd2: begin
                        op_a = kdd;
                        if (tsp_le0_reg) begin
                            op_x = 33'(vd_reg); op_msel = MUL_X100; op_difcap = 1'b1;
                        end else begin
                            op_x = 33'(dspd_reg); op_msel = MUL_X10000;
                        end
                    end
                    default: begin
                        // saturated derivative, scaled back to internal units
                        op_a = 32'(difmag_reg); op_x = 33'(vd_reg); op_fixed = 1'b1;
                    end
                endcase
            end
            default: op_a = '0;
        endcase
        op_neg = op_x[32];
        op_b   = op_fixed ? 32'(SCALE_AS) : abs33(op_x);
    end

    // single shared 32x32 multiplier
    logic [31:0] mul_x;
    logic [31:0] mul_y;
    logic [63:0] prod;

    always_comb begin
        if (cmd.mul_a) begin
            mul_x = op_a;
            mul_y = op_b;
        end else if (cmd.mul_b) begin
            mul_x = p1_reg[31:0];
            mul_y = mult_val(msel_reg);
        end else if (cmd.div_step) begin
            mul_x = 32'(y_reg);
            mul_y = recip;
        end else begin
            mul_x = p1_reg[63:32];
            mul_y = mult_val(msel_reg);
        end
        prod = 64'(mul_x) * 64'(mul_y);
    end

    // term magnitude and accumulation
    logic [63:0]      t_full;
    logic [ACC_W-1:0] t_mag0;
    logic [ACC_W-1:0] t_mag;
    logic [ACC_W-1:0] t_signed;
    logic [ACC_W-1:0] d_shift;
    logic [ACC_W-1:0] d_cap;
    logic [15:0]      difmag_n;

    always_comb begin
        t_full   = plo_reg + {phi_reg[31:0], 32'd0};
        t_mag0   = sat_reg ? ACC_W'(TERM_LIM) : ACC_W'(t_full);
        t_mag    = (iclamp_reg && (t_mag0 > ICLAMP)) ? ICLAMP : t_mag0;
        t_signed = neg_reg ? (ACC_W'(0) - t_mag) : t_mag;
        d_shift  = t_mag >> 16;
        d_cap    = vd_reg[17] ? ACC_W'(32768) : ACC_W'(32767);
        difmag_n = (d_shift > d_cap) ? d_cap[15:0] : d_shift[15:0];
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            acc_reg <= '0;
        end
        if (cmd.mul_a) begin
            p1_reg     <= prod;
            neg_reg    <= op_neg;
            msel_reg   <= op_msel;
            iclamp_reg <= op_iclamp;
            difcap_reg <= op_difcap;
        end
        if (cmd.mul_b) begin
            sat_reg <= (p1_reg > mult_lim(msel_reg));
            plo_reg <= prod;
        end
        if (cmd.mul_c) begin
            phi_reg <= prod;
        end
        if (cmd.acc) begin
            if (difcap_reg) begin
                difmag_reg <= difmag_n;
            end else begin
                acc_reg <= acc_reg + t_signed;
            end
        end
    end

    // trunc toward zero by the fixed scale: drop the 2^16 factor, then a
    // reciprocal multiply for the /1000 or /100 on the shared multiplier
    logic [ACC_W-1:0]   acc_mag;
    logic [ACC_W-1:0]   over_lim;
    logic [DRIVE_W-1:0] lim;
    logic [QUO_W-1:0]   quo;
    logic [DRIVE_W-1:0] val;
    logic [DRIVE_W-1:0] drive_fin;

    always_comb begin
        acc_mag = acc_reg[ACC_W-1] ? (ACC_W'(0) - acc_reg) : acc_reg;
        case (cfg.loop_mode)
            MODE_VEL: begin
                over_lim = OVER_VEL; lim = LIM_VEL; recip = RECIP_VA; div_as = 1'b0;
            end
            MODE_ANG: begin
                over_lim = OVER_ANG; lim = LIM_ANG; recip = RECIP_VA; div_as = 1'b0;
            end
            default: begin
                over_lim = OVER_ASYM; lim = LIM_ASYM; recip = RECIP_AS; div_as = 1'b1;
            end
        endcase
        quo       = div_as ? prod[RSH_AS +: QUO_W] : prod[RSH_VA +: QUO_W];
        val       = over_reg ? lim : DRIVE_W'(q_reg);
        drive_fin = sign_reg ? (DRIVE_W'(0) - val) : val;
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_init) begin
            // below the clamp bound the shifted magnitude fits in 24 bits
            y_reg    <= acc_mag[16 +: DIV_Y_W];
            over_reg <= (acc_mag >= over_lim);
            sign_reg <= acc_reg[ACC_W-1];
        end
        if (cmd.div_step) begin
            q_reg <= quo;
        end
    end

    // output register, decoupled from the input side
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_out_motor_reg <= motor_reg;
            m_drive_reg     <= skip_reg ? '0 : drive_fin;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_motor = m_out_motor_reg;
    assign m_drive     = m_drive_reg;

    always_comb begin
        status.skip      = skip_reg;
        status.out_busy  = m_valid_reg && !m_ready;
        if ((cfg.loop_mode == MODE_ASYM) && tsp_le0_reg) begin
            status.last_term = (cmd.term_idx == 2'd3);
        end else begin
            status.last_term = (cmd.term_idx == 2'd2);
        end
    end

endmodule
`default_nettype wire

// File: sv/motor_speed_angle_pid.sv
// top level: configuration registers, sequencer and datapath
`default_nettype none
// Speed/angle PID for up to MOTOR_COUNT motors. Each input beat is one feedback
// sample with its targets; the block updates that motor's errors and error sums
// and returns one drive value per beat in the mode set by loop_mode (velocity,
// angle, or asymmetric derivative). A beat steps through the accept, then for
// each gain term three products on the single shared 32x32 multiplier and an
// accumulate (3 terms; 4 in asymmetric mode with a non-positive speed target),
// then the clamp check, one reciprocal multiply for the divide by the fixed
// output scale, and the output load. Beats for an out-of-range motor or
// loop_mode 3 skip the terms and divide and give drive 0. The result shows on
// m_valid the cycle after the load; the load waits while the previous result
// is still held in the output register. Configuration must be written through
// cfg_wr_en/cfg_index/cfg_wdata only while idle; the block does not enforce it.
module motor_speed_angle_pid #(
    parameter int  MOTOR_COUNT     = 4,
    parameter int  COUNTS_PER_TURN = 8192,
    localparam int IDX_W           = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1,
    localparam int ENC_W           = $clog2(COUNTS_PER_TURN)
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   cfg_wr_en,
    input  wire logic [mspid_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [mspid_pkg::GAIN_W-1:0]           cfg_wdata,
    input  wire logic                                   s_valid,
    output logic                                        s_ready,
    input  wire logic [IDX_W-1:0]                       s_motor_index,
    input  wire logic [ENC_W-1:0]                       s_encoder,
    input  wire logic signed [mspid_pkg::SPEED_W-1:0]   s_speed,
    input  wire logic signed [mspid_pkg::SPEED_W-1:0]   s_target_speed,
    input  wire logic [ENC_W-1:0]                       s_target_angle,
    output logic                                        m_valid,
    input  wire logic                                   m_ready,
    output logic [IDX_W-1:0]                            m_out_motor,
    output logic signed [mspid_pkg::DRIVE_W-1:0]        m_drive
);
    import mspid_pkg::*;

    cfg_t    cfg_reg, cfg_next;
    cmd_t    cmd;
    status_t status;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_VEL_KP:    cfg_next.vel_kp    = cfg_wdata;
                REG_VEL_KI:    cfg_next.vel_ki    = cfg_wdata;
                REG_VEL_KD:    cfg_next.vel_kd    = cfg_wdata;
                REG_ANG_KP:    cfg_next.ang_kp    = cfg_wdata;
                REG_ANG_KI:    cfg_next.ang_ki    = cfg_wdata;
                REG_ANG_KD:    cfg_next.ang_kd    = cfg_wdata;
                REG_LOOP_MODE: cfg_next.loop_mode = loop_mode_t'(cfg_wdata[1:0]);
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    mspid_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    mspid_datapath #(
        .MOTOR_COUNT     (MOTOR_COUNT),
        .COUNTS_PER_TURN (COUNTS_PER_TURN)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .cfg            (cfg_reg),
        .s_motor_index  (s_motor_index),
        .s_encoder      (s_encoder),
        .s_speed        (s_speed),
        .s_target_speed (s_target_speed),
        .s_target_angle (s_target_angle),
        .m_ready        (m_ready),
        .status         (status),
        .m_valid        (m_valid),
        .m_out_motor    (m_out_motor),
        .m_drive        (m_drive)
    );

endmodule
`default_nettype wire
